@@ sv/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and widths for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int HALF_W  = MAG_W / 2;
	localparam int SUM_W   = 2 * MAG_W;
	localparam int ROOT_W  = MAG_W;
	localparam int REM_W   = ROOT_W + 2;
	localparam int QUO_W   = 17;
	localparam int FRAC_W  = 15;
	localparam int OUT_W   = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner0_x;
		logic signed [COORD_W-1:0] corner0_y;
		logic signed [COORD_W-1:0] corner0_z;
		logic signed [COORD_W-1:0] corner1_x;
		logic signed [COORD_W-1:0] corner1_y;
		logic signed [COORD_W-1:0] corner1_z;
		logic signed [COORD_W-1:0] corner2_x;
		logic signed [COORD_W-1:0] corner2_y;
		logic signed [COORD_W-1:0] corner2_z;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic                    degenerate;
	} out_word_t;

	typedef struct packed {
		logic                        valid;
		logic                        degen;
		logic [2:0]                  sign;
		logic [2:0][MAG_W-1:0]       mag;
		logic [SUM_W-1:0]            x;
		logic [ROOT_W-1:0]           root;
		logic [REM_W-1:0]            rem;
	} sqrt_t;

	typedef struct packed {
		logic                        valid;
		logic                        degen;
		logic [2:0]                  sign;
		logic [ROOT_W-1:0]           len;
		logic [2:0][ROOT_W-1:0]      r;
		logic [2:0][QUO_W-1:0]       nb;
		logic [2:0][QUO_W-1:0]       q;
	} div_t;

endpackage

@@ sv/tun_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One digit step of the integer square root: resolves one root bit.
// ----------------------------------------------------------------------------
module tun_sqrt_cell import tun_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  sqrt_t d,
	output sqrt_t q
);

	logic [REM_W+1:0] remn;
	logic [REM_W+1:0] trial;
	logic             take;

	always_comb begin
		remn  = {d.rem, d.x[SUM_W-1 -: 2]};
		trial = {2'b00, d.root, 2'b01};
		take  = remn >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.degen <= d.degen;
			q.sign  <= d.sign;
			q.mag   <= d.mag;
			q.x     <= {d.x[SUM_W-3:0], 2'b00};
			q.root  <= {d.root[ROOT_W-2:0], take};
			q.rem   <= take ? REM_W'(remn - trial) : REM_W'(remn);
		end
	end

endmodule

@@ sv/tun_div_cell.sv @@
// ----------------------------------------------------------------------------
// tun_div_cell
// One restoring division step on three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module tun_div_cell import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  div_t d,
	output div_t q
);

	logic [2:0][ROOT_W:0] rn;
	logic [2:0]           take;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rn[i]   = {d.r[i], d.nb[i][QUO_W-1]};
			take[i] = rn[i] >= {1'b0, d.len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.degen <= d.degen;
			q.sign  <= d.sign;
			q.len   <= d.len;
			for (int i = 0; i < 3; i++) begin
				q.r[i]  <= take[i] ? ROOT_W'(rn[i] - {1'b0, d.len}) : ROOT_W'(rn[i]);
				q.nb[i] <= {d.nb[i][QUO_W-2:0], 1'b0};
				q.q[i]  <= {d.q[i][QUO_W-2:0], take[i]};
			end
		end
	end

endmodule

@@ sv/triangle_unit_normal_top.sv @@
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit facet normal of a wound triangle, Q8.8 corners in, Q1.15 normal out.
//
// One input word holds the three corners; one output word holds the normal
// and the degenerate flag. Both channels use valid/ready.
// Throughput: one triangle per cycle while the output is not stalled.
// The pipeline is the arithmetic front end (7 stages), a chain of 34
// square-root cells (one root bit each) and a chain of 17 divider cells
// (one quotient bit each, three components side by side), plus the
// output register.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a word waiting, every stage holds and in_ready drops until the
// word is taken. Empty stages do not block.
// Reset clears every stage valid bit; no words are in flight after reset.
// A zero cross product returns (0, 0, 32767) with degenerate set.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top import tun_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [DIFF_W-1:0]  ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PROD_W-1:0]  pa_s2 [3];
	logic signed [PROD_W-1:0]  pb_s2 [3];
	logic signed [CROSS_W-1:0] c_s3 [3];
	logic [2:0]                sign_s4, sign_s5, sign_s6, sign_s7;
	logic [2:0][MAG_W-1:0]     mag_s4, mag_s5, mag_s6, mag_s7;
	logic                      zero_s4, zero_s5, zero_s6, zero_s7;
	logic [MAG_W-1:0]          a2_s5 [3];
	logic [MAG_W-1:0]          ab_s5 [3];
	logic [MAG_W-1:0]          b2_s5 [3];
	logic [SUM_W-1:0]          sq_s6 [3];
	logic [SUM_W-1:0]          sum_s7;

	logic signed [CROSS_W-1:0] neg_c [3];

	sqrt_t sq_chain [35];
	div_t  dv_chain [18];

	logic      out_v_q;
	out_word_t out_q;
	out_word_t res;

	assign en        = !out_v_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			out_v_q <= dv_chain[17].valid;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = -c_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DIFF_W'(in_word.corner1_x) - DIFF_W'(in_word.corner0_x);
			uy_s1 <= DIFF_W'(in_word.corner1_y) - DIFF_W'(in_word.corner0_y);
			uz_s1 <= DIFF_W'(in_word.corner1_z) - DIFF_W'(in_word.corner0_z);
			vx_s1 <= DIFF_W'(in_word.corner2_x) - DIFF_W'(in_word.corner0_x);
			vy_s1 <= DIFF_W'(in_word.corner2_y) - DIFF_W'(in_word.corner0_y);
			vz_s1 <= DIFF_W'(in_word.corner2_z) - DIFF_W'(in_word.corner0_z);

			pa_s2[0] <= PROD_W'(uy_s1) * PROD_W'(vz_s1);
			pb_s2[0] <= PROD_W'(uz_s1) * PROD_W'(vy_s1);
			pa_s2[1] <= PROD_W'(uz_s1) * PROD_W'(vx_s1);
			pb_s2[1] <= PROD_W'(ux_s1) * PROD_W'(vz_s1);
			pa_s2[2] <= PROD_W'(ux_s1) * PROD_W'(vy_s1);
			pb_s2[2] <= PROD_W'(uy_s1) * PROD_W'(vx_s1);

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= {pa_s2[i][PROD_W-1], pa_s2[i]} - {pb_s2[i][PROD_W-1], pb_s2[i]};
			end

			for (int i = 0; i < 3; i++) begin
				sign_s4[i] <= c_s3[i][CROSS_W-1];
				mag_s4[i]  <= c_s3[i][CROSS_W-1] ? neg_c[i][MAG_W-1:0]
				                                 : c_s3[i][MAG_W-1:0];
			end
			zero_s4 <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);

			for (int i = 0; i < 3; i++) begin
				a2_s5[i] <= MAG_W'(mag_s4[i][MAG_W-1:HALF_W])
				          * MAG_W'(mag_s4[i][MAG_W-1:HALF_W]);
				ab_s5[i] <= MAG_W'(mag_s4[i][MAG_W-1:HALF_W])
				          * MAG_W'(mag_s4[i][HALF_W-1:0]);
				b2_s5[i] <= MAG_W'(mag_s4[i][HALF_W-1:0])
				          * MAG_W'(mag_s4[i][HALF_W-1:0]);
			end
			sign_s5 <= sign_s4;
			mag_s5  <= mag_s4;
			zero_s5 <= zero_s4;

			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= {a2_s5[i], {MAG_W{1'b0}}}
				          + {{(HALF_W-1){1'b0}}, ab_s5[i], {(HALF_W+1){1'b0}}}
				          + {{MAG_W{1'b0}}, b2_s5[i]};
			end
			sign_s6 <= sign_s5;
			mag_s6  <= mag_s5;
			zero_s6 <= zero_s5;

			sum_s7  <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			sign_s7 <= sign_s6;
			mag_s7  <= mag_s6;
			zero_s7 <= zero_s6;

			out_q <= res;
		end
	end

	always_comb begin
		sq_chain[0].valid = v_s7;
		sq_chain[0].degen = zero_s7;
		sq_chain[0].sign  = sign_s7;
		sq_chain[0].mag   = mag_s7;
		sq_chain[0].x     = sum_s7;
		sq_chain[0].root  = '0;
		sq_chain[0].rem   = '0;
	end

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		tun_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (sq_chain[g]),
			.q      (sq_chain[g+1])
		);
	end

	always_comb begin
		dv_chain[0].valid = sq_chain[ROOT_W].valid;
		dv_chain[0].degen = sq_chain[ROOT_W].degen;
		dv_chain[0].sign  = sq_chain[ROOT_W].sign;
		dv_chain[0].len   = sq_chain[ROOT_W].root;
		for (int i = 0; i < 3; i++) begin
			dv_chain[0].r[i]  = {2'b00, sq_chain[ROOT_W].mag[i][MAG_W-1:2]};
			dv_chain[0].nb[i] = {sq_chain[ROOT_W].mag[i][1:0], {FRAC_W{1'b0}}};
			dv_chain[0].q[i]  = '0;
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		tun_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (dv_chain[g]),
			.q      (dv_chain[g+1])
		);
	end

	logic [2:0][OUT_W-1:0] comp;
	logic [QUO_W-1:0]      qv;
	logic [QUO_W-1:0]      qneg;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv = dv_chain[QUO_W].q[i];
			if (dv_chain[QUO_W].sign[i]) begin
				qneg    = -((qv > QUO_W'(32768)) ? QUO_W'(32768) : qv);
				comp[i] = qneg[OUT_W-1:0];
			end else begin
				qneg    = '0;
				comp[i] = (qv > QUO_W'(32767)) ? OUT_W'(32767) : qv[OUT_W-1:0];
			end
		end
		if (dv_chain[QUO_W].degen) begin
			res.normal_x   = '0;
			res.normal_y   = '0;
			res.normal_z   = OUT_W'(32767);
			res.degenerate = 1'b1;
		end else begin
			res.normal_x   = comp[0];
			res.normal_y   = comp[1];
			res.normal_z   = comp[2];
			res.degenerate = 1'b0;
		end
	end

endmodule
